[src/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef logic [31:0] word_t;

	// one queued input word
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} item_t;

	// handshake between front queue and back engine
	typedef struct packed {
		logic  valid;
		item_t item;
	} front_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} back_state_t;

	localparam logic       ACT_ABSORB = 1'b0;
	localparam logic       ACT_FINISH = 1'b1;
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_START  = 6'd56;
	localparam logic [5:0] BLK_LAST   = 6'd63;
	localparam logic [2:0] WORD_LAST  = 3'd7;

	localparam word_t H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_s0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_s1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_s0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_s1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

[src/sha_front.sv]
// ----------------------------------------------------------------------------
// sha_front
// Input queue: takes words from the push side and holds them for the engine.
// ----------------------------------------------------------------------------
module sha_front #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  sha_pkg::item_t push_item,
	output sha_pkg::front_t head,
	input  logic           take
);
	import sha_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;
	logic           do_push;
	logic           do_take;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign do_push = push && !full;
	assign do_take = take && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_take) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_take);
		end
	end

endmodule

[src/sha_back.sv]
// ----------------------------------------------------------------------------
// sha_back
// Hash engine: byte buffer, padding sequencer, round unit and digest output.
// ----------------------------------------------------------------------------
module sha_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sha_pkg::front_t head,
	output logic            take,
	input  logic            pop,
	output logic            empty,
	output logic [31:0]     digest_word,
	output logic [2:0]      word_index,
	output logic            last_word
);
	import sha_pkg::*;

	back_state_t state_q, state_d;

	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [5:0]   round_q;
	logic [63:0]  bits_q;
	logic         fin_q;
	logic         lendone_q;
	logic [2:0]   idx_q;
	word_t        h_q [8];
	word_t        v_q [8];
	logic         ovalid_q;
	word_t        oword_q;
	logic [2:0]   oidx_q;

	logic         insert;
	logic [7:0]   ins_byte;
	logic         load_out;
	logic         blk_full;
	word_t        w_new;
	word_t        t1;
	word_t        t2;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					if (blk_full) state_d = ST_ROUND;
					else if (head.item.action == ACT_FINISH) state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (fill_q == LEN_START) state_d = ST_LEN;
				else if (blk_full) state_d = ST_ROUND;
			end
			ST_LEN: begin
				if (blk_full) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (round_q == BLK_LAST) state_d = ST_ADD;
			end
			ST_ADD: begin
				if (lendone_q) state_d = ST_EMIT;
				else if (fin_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (load_out && idx_q == WORD_LAST) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		take     = 1'b0;
		insert   = 1'b0;
		ins_byte = '0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				take     = head.valid;
				insert   = head.valid;
				ins_byte = (head.item.action == ACT_FINISH) ? PAD_MARK
					: head.item.data_byte;
			end
			ST_PAD: begin
				insert = (fill_q != LEN_START);
			end
			ST_LEN: begin
				insert   = 1'b1;
				ins_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];
			end
			ST_EMIT: begin
				load_out = !ovalid_q || pop;
			end
			default: ;
		endcase
	end

	assign blk_full = insert && (fill_q == BLK_LAST);

	// message schedule and round math
	always_comb begin
		w_new = small_s1(blk_q[511-32*14 -: 32]) + blk_q[511-32*9 -: 32]
			+ small_s0(blk_q[511-32 -: 32]) + blk_q[511 -: 32];
		t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[round_q] + blk_q[511 -: 32];
		t2 = big_s0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// block buffer and working variables
	always_ff @(posedge clk) begin
		if (insert) begin
			blk_q <= {blk_q[503:0], ins_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (blk_full) begin
			v_q <= h_q;
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (load_out) begin
			oword_q <= h_q[idx_q];
			oidx_q  <= idx_q;
		end
	end

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			round_q   <= '0;
			bits_q    <= '0;
			fin_q     <= 1'b0;
			lendone_q <= 1'b0;
			idx_q     <= '0;
			h_q       <= H_INIT;
			ovalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (insert) begin
				fill_q <= fill_q + 1'b1;
			end
			if (take && head.item.action == ACT_ABSORB) begin
				bits_q <= bits_q + 64'd8;
			end
			if (take && head.item.action == ACT_FINISH) begin
				fin_q <= 1'b1;
			end
			if (state_q == ST_LEN && blk_full) begin
				lendone_q <= 1'b1;
			end
			if (state_q == ST_ROUND) begin
				round_q <= round_q + 1'b1;
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			// output slot
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
			if (load_out) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == WORD_LAST) begin
					h_q       <= H_INIT;
					bits_q    <= '0;
					fin_q     <= 1'b0;
					lendone_q <= 1'b0;
				end
			end
		end
	end

	assign empty       = !ovalid_q;
	assign digest_word = oword_q;
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == WORD_LAST);

endmodule

[src/sha256_stream_hasher.sv]
// Absorb word: its byte is shifted into the block buffer; every 64th byte is followed by the
// 64 rounds of the single shared round unit and the chaining add, while no words are taken.
// Finish word: padding and length one byte per cycle, one or two block compressions,
// then 8 digest words, one per cycle when popped.
// Input queue holds QUEUE_DEPTH words (4 by default); the output register holds one digest word.
// Reset (arst_n low) empties both queues and restores the initial hash values.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256: message bytes in, eight digest words out per message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	item_t  push_item;
	front_t head;
	logic   take;

	assign push_item.action    = action;
	assign push_item.data_byte = data_byte;

	// input queue
	sha_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.push_item(push_item),
		.head     (head),
		.take     (take)
	);

	// hash engine
	sha_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.take       (take),
		.pop        (pop),
		.empty      (empty),
		.digest_word(digest_word),
		.word_index (word_index),
		.last_word  (last_word)
	);

endmodule

[src/sha_checker.sv]
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the digest word stream.
// ----------------------------------------------------------------------------
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);
	import sha_pkg::*;

	// last flag marks the eighth word only
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_word == (word_index == WORD_LAST)))
		else $error("last_word does not match word_index");

	// words of one digest come in order
	a_idx_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_word) |=>
		(empty || word_index == $past(word_index) + 3'd1))
		else $error("digest word out of order");

	// a new digest needs a full compression, so the queue runs dry after the last
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && last_word) |=> empty)
		else $error("word right after last digest word");

	// waiting word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(digest_word)))
		else $error("waiting digest word changed");

endmodule

bind sha256_stream_hasher sha_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.digest_word(digest_word),
	.word_index (word_index),
	.last_word  (last_word)
);
